// ===== rtl/dbts_pkg.sv =====
package dbts_pkg;

   localparam int QUAD_CAPACITY   = 16384;
   localparam int LINE_CAPACITY   = 8192;
   localparam int CIRCLE_CAPACITY = 4096;
   localparam int SLOT_COUNT      = 32;

   localparam int KEY_DEPTH  = 32;
   localparam int SLOT_W     = $clog2(KEY_DEPTH);
   localparam int USED_W     = SLOT_W + 1;
   localparam int KEY_W      = 32;
   localparam int QUAD_CNT_W   = $clog2(QUAD_CAPACITY + 1);
   localparam int LINE_CNT_W   = $clog2(LINE_CAPACITY + 1);
   localparam int CIRCLE_CNT_W = $clog2(CIRCLE_CAPACITY + 1);

   typedef enum logic [2:0] {
      ACT_BEGIN   = 3'd0,
      ACT_END     = 3'd1,
      ACT_COLOR   = 3'd2,
      ACT_TEXTURE = 3'd3,
      ACT_LINE    = 3'd4,
      ACT_CIRCLE  = 3'd5
   } action_type;

   typedef struct packed {
      logic [2:0]       action;
      logic [KEY_W-1:0] texture_key;
   } req_type;

   typedef struct packed {
      logic              flushed;
      logic [1:0]        draws_issued;
      logic [SLOT_W-1:0] texture_slot;
      logic              slot_new;
   } rsp_type;

   // Sequencing commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic match;
      logic apply;
   } ctrl_cmd_type;

endpackage

// ===== rtl/dbts_ctrl.sv =====
module dbts_ctrl
   import dbts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MATCH = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff == ST_MATCH);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            // A new beat may enter while the previous one is applied.
            state_in = accept ? ST_MATCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.load  = accept;
   assign cmd.match = (state_ff == ST_MATCH);
   assign cmd.apply = (state_ff == ST_APPLY);

endmodule

// ===== rtl/dbts_datapath.sv =====
module dbts_datapath
   import dbts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  req_type      req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   req_type                 req_ff;
   logic [KEY_W-1:0]        keys_ff [KEY_DEPTH];
   logic [KEY_DEPTH-1:0]    match_ff, match_in;
   logic [USED_W-1:0]       slots_used_ff, slots_used_in;
   logic [QUAD_CNT_W-1:0]   quad_count_ff, quad_count_in;
   logic [LINE_CNT_W-1:0]   line_count_ff, line_count_in;
   logic [CIRCLE_CNT_W-1:0] circle_count_ff, circle_count_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic                    key_we;
   logic [SLOT_W-1:0]       key_waddr;
   logic [SLOT_W-1:0]       hit_slot;
   logic                    hit;
   logic                    quad_full, line_full, circle_full;
   logic                    flush;
   logic [1:0]              nonempty;
   logic [USED_W-1:0]       base_used;

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // All slots in use other than slot 0 are compared against the key at once.
   always_comb begin
      for (int i = 0; i < KEY_DEPTH; i++) begin
         match_in[i] = (keys_ff[i] == req_ff.texture_key) && (i != 0) &&
                       (USED_W'(i) < slots_used_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) match_ff <= match_in;
   end

   always_comb begin
      hit_slot = '0;
      for (int i = KEY_DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_slot = SLOT_W'(i);
      end
   end

   assign quad_full   = (quad_count_ff >= QUAD_CNT_W'(QUAD_CAPACITY));
   assign line_full   = (line_count_ff >= LINE_CNT_W'(LINE_CAPACITY));
   assign circle_full = (circle_count_ff >= CIRCLE_CNT_W'(CIRCLE_CAPACITY));
   assign nonempty    = {1'b0, quad_count_ff != '0} + {1'b0, line_count_ff != '0} +
                        {1'b0, circle_count_ff != '0};

   always_comb begin
      rsp_in          = '0;
      slots_used_in   = slots_used_ff;
      quad_count_in   = quad_count_ff;
      line_count_in   = line_count_ff;
      circle_count_in = circle_count_ff;
      key_we          = 1'b0;
      key_waddr       = slots_used_ff[SLOT_W-1:0];
      flush           = 1'b0;
      hit             = 1'b0;
      base_used       = slots_used_ff;
      case (req_ff.action)
         ACT_BEGIN: begin
            flush = 1'b1;
         end
         ACT_END: begin
            rsp_in.draws_issued = nonempty;
         end
         ACT_COLOR: begin
            flush = quad_full;
         end
         ACT_TEXTURE: begin
            // A flush for a full quad batch empties the table, so nothing can hit.
            hit   = (|match_ff) && !quad_full;
            flush = quad_full || (!hit && (slots_used_ff >= USED_W'(SLOT_COUNT)));
         end
         ACT_LINE: begin
            flush = line_full;
         end
         ACT_CIRCLE: begin
            flush = circle_full;
         end
         default: begin
         end
      endcase

      if (flush) begin
         quad_count_in   = '0;
         line_count_in   = '0;
         circle_count_in = '0;
         slots_used_in   = USED_W'(1);
         base_used       = USED_W'(1);
         if (req_ff.action != ACT_BEGIN) begin
            rsp_in.flushed      = 1'b1;
            rsp_in.draws_issued = nonempty;
         end
      end

      case (req_ff.action)
         ACT_COLOR: begin
            quad_count_in = quad_count_in + QUAD_CNT_W'(1);
         end
         ACT_TEXTURE: begin
            quad_count_in = quad_count_in + QUAD_CNT_W'(1);
            if (hit) begin
               rsp_in.texture_slot = hit_slot;
            end else begin
               key_we              = 1'b1;
               key_waddr           = base_used[SLOT_W-1:0];
               rsp_in.texture_slot = base_used[SLOT_W-1:0];
               rsp_in.slot_new     = 1'b1;
               slots_used_in       = base_used + USED_W'(1);
            end
         end
         ACT_LINE: begin
            line_count_in = line_count_in + LINE_CNT_W'(1);
         end
         ACT_CIRCLE: begin
            circle_count_in = circle_count_in + CIRCLE_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && key_we) keys_ff[key_waddr] <= req_ff.texture_key;
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff   <= USED_W'(1);
         quad_count_ff   <= '0;
         line_count_ff   <= '0;
         circle_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.apply;
         if (cmd.apply) begin
            slots_used_ff   <= slots_used_in;
            quad_count_ff   <= quad_count_in;
            line_count_ff   <= line_count_in;
            circle_count_ff <= circle_count_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/draw_batch_texture_slot_manager_core.sv =====
// Steps: the beat is registered on acceptance, the parallel key match is registered next,
// and flush, allocation and counting are then applied and the result strobe registered.
// A new command may be accepted while the previous one is applied, but not while busy.
// Reset clears the batch counters and sets the slots in use to one; the key table
// is not cleared, and only allocated slots are ever compared. The receiver cannot stall.
module draw_batch_texture_slot_manager_core
   import dbts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;

   dbts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   dbts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not enter the match cycle");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("match cycle lasted longer than one cycle");

   a_busy_gives_result: assert property (@(posedge clock) disable iff (reset)
      busy |-> ##2 rsp_valid)
      else $error("matched command produced no result");

   a_new_slot_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.slot_new) |-> (rsp_data.texture_slot != '0))
      else $error("new key placed in the white slot");

   a_flush_draws: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.flushed) |-> (rsp_data.draws_issued != 2'd0))
      else $error("flush reported without any batch drawn");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   import dbts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ACT_RESERVED_LO = 3'd6;
   localparam logic [2:0] ACT_RESERVED_HI = 3'd7;
   localparam int QUIET_LIMIT = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   draw_batch_texture_slot_manager_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_cmds [$];
   rsp_type expected_rsp [$];
   int      idle_pct = 0;
   int      fail_count = 0;
   int      quiet_cycles = 0;

   // Shadow of the batch counters and the texture slot table.
   logic [KEY_W-1:0]        slot_key_shadow [KEY_DEPTH];
   logic [USED_W-1:0]       slots_in_use = USED_W'(1);
   logic [QUAD_CNT_W-1:0]   quad_total = '0;
   logic [LINE_CNT_W-1:0]   line_total = '0;
   logic [CIRCLE_CNT_W-1:0] circle_total = '0;

   function automatic logic [1:0] live_batches();
      return 2'((quad_total != 0) + (line_total != 0) + (circle_total != 0));
   endfunction

   function void empty_batches();
      quad_total   = '0;
      line_total   = '0;
      circle_total = '0;
      slots_in_use = USED_W'(1);
   endfunction

   function logic [1:0] flush_batches();
      logic [1:0] n;
      n = live_batches();
      empty_batches();
      return n;
   endfunction

   function rsp_type predict_command(req_type cmd);
      rsp_type r;
      logic    hit;
      r   = '0;
      hit = 1'b0;
      case (cmd.action)
         ACT_BEGIN: empty_batches();
         ACT_END: r.draws_issued = live_batches();
         ACT_COLOR: begin
            if (quad_total >= QUAD_CAPACITY) begin
               r.draws_issued = flush_batches();
               r.flushed      = 1'b1;
            end
            quad_total++;
         end
         ACT_TEXTURE: begin
            if (quad_total >= QUAD_CAPACITY) begin
               r.draws_issued = flush_batches();
               r.flushed      = 1'b1;
            end
            // Slot 0 is the white texture and never takes part in the search.
            for (int i = 1; i < KEY_DEPTH; i++) begin
               if (!hit && i < slots_in_use && slot_key_shadow[i] == cmd.texture_key) begin
                  r.texture_slot = SLOT_W'(i);
                  hit            = 1'b1;
               end
            end
            if (!hit) begin
               if (slots_in_use >= SLOT_COUNT) begin
                  r.draws_issued = flush_batches();
                  r.flushed      = 1'b1;
               end
               r.texture_slot = slots_in_use[SLOT_W-1:0];
               slot_key_shadow[slots_in_use[SLOT_W-1:0]] = cmd.texture_key;
               slots_in_use++;
               r.slot_new = 1'b1;
            end
            quad_total++;
         end
         ACT_LINE: begin
            if (line_total >= LINE_CAPACITY) begin
               r.draws_issued = flush_batches();
               r.flushed      = 1'b1;
            end
            line_total++;
         end
         ACT_CIRCLE: begin
            if (circle_total >= CIRCLE_CAPACITY) begin
               r.draws_issued = flush_batches();
               r.flushed      = 1'b1;
            end
            circle_total++;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Driver: a beat is accepted at an edge where start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(predict_command(req_data));
         end
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= pending_cmds.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("result beat with no command outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.flushed !== want.flushed) begin
               $error("flushed: expected %0d, got %0d", want.flushed, rsp_data.flushed);
               fail_count++;
            end
            if (rsp_data.draws_issued !== want.draws_issued) begin
               $error("draws_issued: expected %0d, got %0d",
                      want.draws_issued, rsp_data.draws_issued);
               fail_count++;
            end
            if (rsp_data.texture_slot !== want.texture_slot) begin
               $error("texture_slot: expected %0d, got %0d",
                      want.texture_slot, rsp_data.texture_slot);
               fail_count++;
            end
            if (rsp_data.slot_new !== want.slot_new) begin
               $error("slot_new: expected %0d, got %0d", want.slot_new, rsp_data.slot_new);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic add_cmd(logic [2:0] act, logic [KEY_W-1:0] key);
      req_type c;
      c.action      = act;
      c.texture_key = key;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return KEY_W'(1) << $urandom_range(KEY_W - 1);
         default: return $urandom();
      endcase
   endfunction

   // One scene: begin, a run of draws over a small pool of textures, end.
   // Large pools run out of slots; a few beats are noise or break the framing.
   task automatic add_scene();
      logic [KEY_W-1:0] pool [48];
      int pool_n;
      int n_draws;
      int roll;
      pool_n  = $urandom_range(48, 2);
      n_draws = $urandom_range(80, 4);
      for (int i = 0; i < 48; i++) pool[i] = pick_key();
      if ($urandom_range(9) != 0) add_cmd(ACT_BEGIN, $urandom());
      for (int i = 0; i < n_draws; i++) begin
         roll = $urandom_range(99);
         if (roll < 50) add_cmd(ACT_TEXTURE, pool[$urandom_range(pool_n - 1)]);
         else if (roll < 62) add_cmd(ACT_COLOR, $urandom());
         else if (roll < 75) add_cmd(ACT_LINE, $urandom());
         else if (roll < 85) add_cmd(ACT_CIRCLE, $urandom());
         else if (roll < 90) add_cmd(ACT_END, $urandom());
         else if (roll < 95) add_cmd($urandom_range(1) ? ACT_RESERVED_HI : ACT_RESERVED_LO,
                                     $urandom());
         else add_cmd(ACT_BEGIN, $urandom());
      end
      if ($urandom_range(99) < 85) add_cmd(ACT_END, $urandom());
   endtask

   task automatic run_phase(int pct, int n_items);
      idle_pct = pct;
      while (pending_cmds.size() < n_items) add_scene();
      while (pending_cmds.size() != 0 || start || expected_rsp.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Short directed sequence over every action and the corner keys.
      add_cmd(ACT_END, '0);
      add_cmd(ACT_BEGIN, '1);
      add_cmd(ACT_COLOR, '1);
      add_cmd(ACT_TEXTURE, '0);          // the white key still gets slot 1
      add_cmd(ACT_TEXTURE, '0);
      add_cmd(ACT_TEXTURE, '1);
      add_cmd(ACT_TEXTURE, 32'h8000_0000);
      add_cmd(ACT_TEXTURE, '1);
      add_cmd(ACT_LINE, '0);
      add_cmd(ACT_CIRCLE, '1);
      add_cmd(ACT_END, '1);
      add_cmd(ACT_RESERVED_LO, 32'h5555_5555);
      add_cmd(ACT_RESERVED_HI, 32'haaaa_aaaa);
      add_cmd(ACT_CIRCLE, '0);
      add_cmd(ACT_END, '0);
      add_cmd(ACT_BEGIN, '0);
      add_cmd(ACT_END, '0);
      add_cmd(ACT_TEXTURE, 32'h0000_0001);
      add_cmd(ACT_BEGIN, '0);
      add_cmd(ACT_TEXTURE, 32'h0000_0002);  // slot table restarts at 1
      add_cmd(ACT_END, '0);

      // Exhaust the slot table: the first key after the last free slot flushes.
      add_cmd(ACT_BEGIN, '0);
      for (int i = 1; i <= SLOT_COUNT; i++) add_cmd(ACT_TEXTURE, 32'h1000_0000 + i);
      add_cmd(ACT_TEXTURE, 32'h1000_0001);
      add_cmd(ACT_END, '0);

      run_phase(0, 0);
      run_phase(0, 350);
      run_phase(68, 350);
      run_phase(0, 350);
      run_phase(19, 350);

      repeat (8) @(negedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
